/* hdl/rmsw_pkg.sv */
package rmsw_pkg;

    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int RATE_W     = 16;
    localparam int SQ_W       = 47;   // floor(g^2 / 2^16), g magnitude up to 2^31
    localparam int NUM_W      = 48;   // step size * |g|
    localparam int ROOT_W     = 24;   // sqrt of a 48-bit radicand
    localparam int DEN_W      = 25;   // root + epsilon
    localparam int DVD_W      = 49;   // numerator plus half the denominator
    localparam int SQ_N       = 24;   // one root bit per stage
    localparam int DV_N       = 49;   // one quotient bit per stage
    localparam int STORE_MAX  = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [63:0] ROUND_HALF = 64'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_EPSILON   = 2'd2
    } cfg_sel_t;

    typedef struct packed {
        logic [RATE_W-1:0] step_size;
        logic [RATE_W-1:0] decay;
        logic [RATE_W-1:0] epsilon;
    } cfg_t;

    // classified item as it waits in the queue
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] weight;
        logic                     neg;
        logic [DATA_W-1:0]        gmag;
        logic [SQ_W-1:0]          sq;
    } work_t;

    // item after the cache update
    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic                     neg;
        logic [NUM_W-1:0]         num;
        logic [DATA_W-1:0]        cache;
        logic                     sat;
    } cache_res_t;

endpackage

/* hdl/rmsw_if.sv */
interface rmsw_item_if;
    logic                                     valid;
    logic                                     ready;
    logic [rmsw_pkg::IDX_W-1:0]               element_index;
    logic signed [rmsw_pkg::DATA_W-1:0]       weight;
    logic signed [rmsw_pkg::DATA_W-1:0]       gradient;

    modport source (output valid, element_index, weight, gradient, input ready);
    modport sink   (input valid, element_index, weight, gradient, output ready);
endinterface

interface rmsw_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rmsw_pkg::DATA_W-1:0]       new_weight;
    logic [rmsw_pkg::DATA_W-1:0]              new_cache;
    logic                                     saturated;

    modport source (output valid, new_weight, new_cache, saturated, input ready);
    modport sink   (input valid, new_weight, new_cache, saturated, output ready);
endinterface

/* hdl/rmsw_front.sv */
module rmsw_front #(
    parameter int PARAM_COUNT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    rmsw_item_if.sink           items,
    output logic                push,
    output rmsw_pkg::work_t     push_data,
    input  logic                full
);

    localparam int IW = rmsw_pkg::IDX_W;
    localparam int DW = rmsw_pkg::DATA_W;

    logic                 f1_vld_reg;
    logic [IW-1:0]        f1_idx_reg;
    logic signed [DW-1:0] f1_w_reg;
    logic signed [DW-1:0] f1_g_reg;

    logic                 f2_vld_reg;
    logic [IW-1:0]        f2_idx_reg;
    logic signed [DW-1:0] f2_w_reg;
    logic                 f2_neg_reg;
    logic [DW-1:0]        f2_gmag_reg;

    logic                 f2_free;
    logic                 f1_move;
    logic                 accept;
    logic [IW-1:0]        f1_idx_next;
    logic [IW-1:0]        f2_idx_next;
    logic [DW-1:0]        f1_gmag;
    logic [63:0]          prod;

    // restoring reduction by the element count, over the shift range lo..hi
    function automatic logic [IW-1:0] mod_steps(input logic [IW-1:0] v, input int hi,
                                                input int lo);
        logic [IW-1:0] r;
        longint        m;
        r = v;
        for (int k = IW - 1; k >= 0; k--) begin
            m = longint'(PARAM_COUNT) << k;
            if ((k <= hi) && (k >= lo) && (m < (longint'(1) << IW))) begin
                if (r >= m[IW-1:0]) begin
                    r = r - m[IW-1:0];
                end
            end
        end
        return r;
    endfunction

    assign push    = f2_vld_reg && !full;
    assign f2_free = !f2_vld_reg || push;
    assign f1_move = f1_vld_reg && f2_free;
    assign accept  = items.valid && items.ready;
    assign items.ready = enable && (!f1_vld_reg || f2_free);

    always_comb
    begin
        f1_idx_next = mod_steps(f1_idx_reg, IW - 1, IW / 2);
        f2_idx_next = mod_steps(f2_idx_reg, IW / 2 - 1, 0);
        f1_gmag     = f1_g_reg[DW-1] ? DW'(-f1_g_reg) : DW'(f1_g_reg);
        prod        = 64'(f2_gmag_reg) * 64'(f2_gmag_reg);
        push_data.idx    = f2_idx_next;
        push_data.weight = f2_w_reg;
        push_data.neg    = f2_neg_reg;
        push_data.gmag   = f2_gmag_reg;
        push_data.sq     = prod[16 +: rmsw_pkg::SQ_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept || f1_move)
            begin
                f1_vld_reg <= accept;
            end
            if (f2_free)
            begin
                f2_vld_reg <= f1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_idx_reg <= items.element_index;
            f1_w_reg   <= items.weight;
            f1_g_reg   <= items.gradient;
        end
        if (f1_move)
        begin
            f2_idx_reg  <= f1_idx_next;
            f2_w_reg    <= f1_w_reg;
            f2_neg_reg  <= f1_g_reg[DW-1];
            f2_gmag_reg <= f1_gmag;
        end
    end

endmodule

/* hdl/rmsw_queue.sv */
module rmsw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rmsw_pkg::work_t     push_data,
    output logic                full,
    output logic                head_valid,
    output rmsw_pkg::work_t     head,
    input  logic                pop
);

    localparam int DEPTH = rmsw_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    rmsw_pkg::work_t slot_reg [0:DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     cnt_reg;

    assign full       = (cnt_reg == (PW+1)'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/rmsw_cache.sv */
module rmsw_cache #(
    parameter int PARAM_COUNT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rmsw_pkg::cfg_t         cfg,
    input  logic                   adv,
    input  logic                   head_valid,
    input  rmsw_pkg::work_t        head,
    output logic                   pop,
    output logic                   busy,
    output logic                   res_valid,
    output rmsw_pkg::cache_res_t   res
);

    localparam int DEPTH  = (PARAM_COUNT < rmsw_pkg::STORE_MAX) ? PARAM_COUNT
                                                                : rmsw_pkg::STORE_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = rmsw_pkg::IDX_W;
    localparam int DW     = rmsw_pkg::DATA_W;
    localparam int LO_W   = 23;
    localparam int HI_W   = rmsw_pkg::SQ_W - LO_W;

    logic [DW-1:0]   mem [0:DEPTH-1];

    logic            busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // stage 1: store read
    logic                 v1_reg;
    rmsw_pkg::work_t      s1_reg;
    logic [DW-1:0]        rd_reg;

    // stage 2: products
    logic                 v2_reg;
    logic [IW-1:0]        idx2_reg;
    logic signed [DW-1:0] w2_reg;
    logic                 neg2_reg;
    logic [47:0]          pa_reg;
    logic [40:0]          pb_lo_reg;
    logic [40:0]          pb_hi_reg;
    logic [rmsw_pkg::NUM_W-1:0] num2_reg;

    logic                 res_v_reg;
    rmsw_pkg::cache_res_t res_reg;

    logic                 hazard;
    logic                 take;
    logic [16:0]          one_minus;
    logic [63:0]          acc;
    logic                 c_sat;
    logic [DW-1:0]        c_val;
    logic                 wr_en;

    assign hazard = (v1_reg && (s1_reg.idx == head.idx)) ||
                    (v2_reg && (idx2_reg == head.idx));
    assign take      = adv && head_valid && !busy_reg && !hazard;
    assign pop       = take;
    assign busy      = busy_reg;
    assign res_valid = res_v_reg;
    assign res       = res_reg;
    assign wr_en     = adv && v2_reg;

    always_comb
    begin
        one_minus = rmsw_pkg::ONE_Q16 - 17'(cfg.decay);
        acc = 64'(pa_reg) + (64'(pb_hi_reg) << LO_W) + 64'(pb_lo_reg) + rmsw_pkg::ROUND_HALF;
        c_sat = |acc[63:48];
        c_val = c_sat ? '1 : acc[47:16];
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[idx2_reg[ADDR_W-1:0]] <= c_val;
        end
        if (take)
        begin
            rd_reg <= mem[head.idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= take;
            v2_reg    <= v1_reg;
            res_v_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= head;
        end
        if (adv)
        begin
            idx2_reg  <= s1_reg.idx;
            w2_reg    <= s1_reg.weight;
            neg2_reg  <= s1_reg.neg;
            pa_reg    <= 48'(cfg.decay) * 48'(rd_reg);
            pb_lo_reg <= 41'(one_minus) * 41'(s1_reg.sq[LO_W-1:0]);
            pb_hi_reg <= 41'(one_minus) * 41'(s1_reg.sq[LO_W +: HI_W]);
            num2_reg  <= rmsw_pkg::NUM_W'(cfg.step_size) * rmsw_pkg::NUM_W'(s1_reg.gmag);
            res_reg.weight <= w2_reg;
            res_reg.neg    <= neg2_reg;
            res_reg.num    <= num2_reg;
            res_reg.cache  <= c_val;
            res_reg.sat    <= c_sat;
        end
    end

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !take)
        else $error("item taken during clearing pass");

    a_no_same_index_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (s1_reg.idx != idx2_reg))
        else $error("read of an element ahead of its pending write");

endmodule

/* hdl/rmsw_solve.sv */
module rmsw_solve (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rmsw_pkg::cfg_t         cfg,
    input  logic                   res_valid,
    input  rmsw_pkg::cache_res_t   res,
    output logic                   adv,
    rmsw_result_if.source          results
);

    localparam int DW  = rmsw_pkg::DATA_W;
    localparam int RW  = rmsw_pkg::ROOT_W;
    localparam int EW  = rmsw_pkg::DEN_W;
    localparam int NW  = rmsw_pkg::DVD_W;
    localparam int SQN = rmsw_pkg::SQ_N;
    localparam int DVN = rmsw_pkg::DV_N;

    typedef struct packed {
        logic signed [DW-1:0]        weight;
        logic                        neg;
        logic [rmsw_pkg::NUM_W-1:0]  num;
        logic [DW-1:0]               cache;
        logic                        sat;
        logic [2*RW-1:0]             x;
        logic [RW+2:0]               rem;
        logic [RW-1:0]               root;
    } sq_stage_t;

    typedef struct packed {
        logic signed [DW-1:0]        weight;
        logic                        neg;
        logic [DW-1:0]               cache;
        logic                        sat;
        logic [EW-1:0]               d;
        logic [NW-1:0]               n;
        logic [EW:0]                 rem;
        logic [NW-1:0]               q;
    } dv_stage_t;

    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t     r;
        logic [RW+2:0] t;
        logic [RW+2:0] trial;
        r     = s;
        t     = {s.rem[RW:0], s.x[2*RW-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.x   = {s.x[2*RW-3:0], 2'b00};
        if (t >= trial)
        begin
            r.rem  = t - trial;
            r.root = {s.root[RW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t;
            r.root = {s.root[RW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_stage_t div_step(input dv_stage_t s);
        dv_stage_t   r;
        logic [EW:0] t;
        r = s;
        t = {s.rem[EW-1:0], s.n[NW-1]};
        r.n = {s.n[NW-2:0], 1'b0};
        if (t >= {1'b0, s.d})
        begin
            r.rem = t - {1'b0, s.d};
            r.q   = {s.q[NW-2:0], 1'b1};
        end
        else
        begin
            r.rem = t;
            r.q   = {s.q[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_stage_t   sq_reg  [0:SQN-1];
    logic        sq_vld_reg [0:SQN-1];
    dv_stage_t   prep_reg;
    logic        prep_vld_reg;
    dv_stage_t   dv_reg  [0:DVN-1];
    logic        dv_vld_reg [0:DVN-1];

    logic                 out_vld_reg;
    logic signed [DW-1:0] out_w_reg;
    logic [DW-1:0]        out_c_reg;
    logic                 out_sat_reg;

    sq_stage_t            sq_init;
    dv_stage_t            prep_next;
    logic [EW-1:0]        den;
    logic signed [NW+1:0] wide_w;
    logic signed [NW+1:0] umag;
    logic signed [NW+1:0] nw;
    logic                 w_hi;
    logic                 w_lo;
    logic signed [DW-1:0] w_final;

    assign adv = !out_vld_reg || results.ready;

    assign results.valid      = out_vld_reg;
    assign results.new_weight = out_w_reg;
    assign results.new_cache  = out_c_reg;
    assign results.saturated  = out_sat_reg;

    always_comb
    begin
        sq_init.weight = res.weight;
        sq_init.neg    = res.neg;
        sq_init.num    = res.num;
        sq_init.cache  = res.cache;
        sq_init.sat    = res.sat;
        sq_init.x      = {res.cache, 16'b0};
        sq_init.rem    = '0;
        sq_init.root   = '0;

        den = EW'(sq_reg[SQN-1].root) + EW'(cfg.epsilon);
        if (den == '0)
        begin
            den = EW'(1);
        end
        prep_next.weight = sq_reg[SQN-1].weight;
        prep_next.neg    = sq_reg[SQN-1].neg;
        prep_next.cache  = sq_reg[SQN-1].cache;
        prep_next.sat    = sq_reg[SQN-1].sat;
        prep_next.d      = den;
        prep_next.n      = NW'(sq_reg[SQN-1].num) + NW'(den >> 1);
        prep_next.rem    = '0;
        prep_next.q      = '0;

        // weight minus the signed step, then clip
        wide_w = (NW+2)'(dv_reg[DVN-1].weight);
        umag   = $signed({2'b00, dv_reg[DVN-1].q});
        nw     = dv_reg[DVN-1].neg ? (wide_w + umag) : (wide_w - umag);
        w_hi   = nw > (NW+2)'(64'sd2147483647);
        w_lo   = nw < -(NW+2)'(64'sd2147483648);
        if (w_hi)
        begin
            w_final = {1'b0, {(DW-1){1'b1}}};
        end
        else if (w_lo)
        begin
            w_final = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            w_final = nw[DW-1:0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < SQN; i++)
        begin : g_sq
            sq_stage_t src;
            logic      src_v;
            if (i == 0)
            begin : g_first
                assign src   = sq_init;
                assign src_v = res_valid;
            end
            else
            begin : g_rest
                assign src   = sq_reg[i-1];
                assign src_v = sq_vld_reg[i-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    sq_vld_reg[i] <= src_v;
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_reg[i] <= sqrt_step(src);
                end
            end
        end

        for (i = 0; i < DVN; i++)
        begin : g_dv
            dv_stage_t src;
            logic      src_v;
            if (i == 0)
            begin : g_first
                assign src   = prep_reg;
                assign src_v = prep_vld_reg;
            end
            else
            begin : g_rest
                assign src   = dv_reg[i-1];
                assign src_v = dv_vld_reg[i-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_vld_reg[i] <= src_v;
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[i] <= div_step(src);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prep_vld_reg <= sq_vld_reg[SQN-1];
            out_vld_reg  <= dv_vld_reg[DVN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg    <= prep_next;
            out_w_reg   <= w_final;
            out_c_reg   <= dv_reg[DVN-1].cache;
            out_sat_reg <= dv_reg[DVN-1].sat || w_hi || w_lo;
        end
    end

    a_sat_means_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_sat_reg) |->
            ((out_c_reg == '1) || (out_w_reg == {1'b0, {(DW-1){1'b1}}}) ||
             (out_w_reg == {1'b1, {(DW-1){1'b0}}})))
        else $error("saturation flag without a clipped value");

endmodule

/* hdl/rmsprop_weight_update_unit.sv */
// Path: front, queue, cache update, square root, divider and output register.
// Throughput: one item per cycle while the result output is not stalled; an item whose element
//   matches one of the two items just ahead of it in the cache update waits at the queue head.
// The square root (24 stages) and the divider (49 stages) give one bit per stage.
// Reset: registers return to their reset values, then a clearing pass zeroes every entry
//   of the cache store; no item is taken until it ends.
module rmsprop_weight_update_unit #(
    parameter int PARAM_COUNT = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rmsw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmsw_pkg::RATE_W-1:0]        cfg_data,
    rmsw_item_if.sink                          items,
    rmsw_result_if.source                      results
);

    // configuration registers
    rmsw_pkg::cfg_t       cfg_reg;

    // front to queue
    logic                 push;
    rmsw_pkg::work_t      push_data;
    logic                 full;

    // queue to cache update
    logic                 head_valid;
    rmsw_pkg::work_t      head;
    logic                 pop;
    logic                 busy;

    // cache update to root / divide
    logic                 res_valid;
    rmsw_pkg::cache_res_t res;
    logic                 adv;

    // Register writes must land only while idle (the block does not enforce this), so no shadowing is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= 16'd66;
            cfg_reg.decay     <= 16'd64881;
            cfg_reg.epsilon   <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (rmsw_pkg::cfg_sel_t'(cfg_index))
                rmsw_pkg::CFG_STEP_SIZE: cfg_reg.step_size <= cfg_data;
                rmsw_pkg::CFG_DECAY:     cfg_reg.decay     <= cfg_data;
                rmsw_pkg::CFG_EPSILON:   cfg_reg.epsilon   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Front: takes items, reduces the index, forms |g| and g^2 / 2^16.
    rmsw_front #(
        .PARAM_COUNT (PARAM_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!busy),
        .items     (items),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Short queue so the front keeps taking items while the back stalls.
    rmsw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back, part one: read-modify-write of the cache store, three stages.
    // Same-element items are held at the queue head rather than forwarded.
    rmsw_cache #(
        .PARAM_COUNT (PARAM_COUNT)
    ) u_cache (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .adv        (adv),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Back, part two: root, denominator, rounded quotient, weight clip and
    // the output register; the whole back pipeline moves on one enable.
    rmsw_solve u_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .adv       (adv),
        .results   (results)
    );

endmodule
